// ===== sv/sobo_pkg.sv =====
// ----------------------------------------------------------------------------
// sobo_pkg
// shared constants, codes and types for the slot occupancy box overlap block
// ----------------------------------------------------------------------------
package sobo_pkg;

  localparam int MAX_DETECTIONS = 64;
  localparam int ADDR_W = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
  localparam int CNT_W  = $clog2(MAX_DETECTIONS + 1);

  localparam int COORD_W = 12;
  localparam int SIZE_W  = 11;
  localparam int CFG_W   = 7;
  localparam int AREA_W  = 2 * SIZE_W;
  localparam int PROD_W  = AREA_W + CFG_W;
  localparam int ENTRY_W = 2 * COORD_W + 2 * SIZE_W;

  localparam int IDX_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  localparam logic [CFG_W-1:0] PCT_SCALE       = 7'd100;
  localparam logic [CFG_W-1:0] OVERLAP_DEFAULT = 7'd50;
  localparam logic [CFG_W-1:0] FACTOR_DEFAULT  = 7'd5;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_TEST  = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic {
    REG_OVERLAP = 1'b0,
    REG_FACTOR  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_AREA,
    S_THR,
    S_WALK,
    S_DONE
  } state_t;

endpackage

// ===== sv/sobo_ram.sv =====
// ----------------------------------------------------------------------------
// sobo_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module sobo_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/slot_occupancy_box_overlap.sv =====
// ----------------------------------------------------------------------------
// slot_occupancy_box_overlap
// detection box store with first-match overlap test of a slot box
// ----------------------------------------------------------------------------
// sequence: clear, add and unused op go straight to the done state, which loads the result
//   register; a test computes the slot area, then the thresholds, then walks the stored
//   boxes until the first match or the end of the store before it loads the result
// throughput: one transaction at a time, the next is accepted in the cycle after the
//   result loads; a test reads one stored box per cycle through a 4-stage pipeline
// reset: box count 0, overlap_percent 50, area_factor 5; ram contents are not cleared
module slot_occupancy_box_overlap import sobo_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  // configuration
  input  logic                       cfg_we,
  input  logic                       cfg_index,
  input  logic [CFG_W-1:0]           cfg_data,
  // input channel
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [1:0]                 op,
  input  logic signed [COORD_W-1:0]  box_left,
  input  logic signed [COORD_W-1:0]  box_top,
  input  logic [SIZE_W-1:0]          box_width,
  input  logic [SIZE_W-1:0]          box_height,
  // output channel
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       occupied,
  output logic [IDX_OUT_W-1:0]       match_index,
  output logic                       store_full,
  output logic [CNT_OUT_W-1:0]       detection_count
);

  state_t state, state_next;

  logic [CFG_W-1:0] overlap_percent;
  logic [CFG_W-1:0] area_factor;
  logic [CNT_W-1:0] count;

  // latched transaction
  op_t                      cur_op;
  logic signed [COORD_W-1:0] sl, st;
  logic [SIZE_W-1:0]         sw, sh;

  // slot setup
  logic signed [COORD_W:0] sl_end, st_end;
  logic [AREA_W-1:0]       slot_area;
  logic [PROD_W-1:0]       thr_ov, thr_af;

  // walk control
  logic [CNT_W-1:0]  rd_ptr;
  logic              found;
  logic [ADDR_W-1:0] match_idx;

  logic issue, out_free, out_load, ram_we, walk_done, is_full, hit;

  // ram
  logic [ENTRY_W-1:0] rdata;

  // pipeline
  logic              v0, v1, v2, v3;
  logic [ADDR_W-1:0] i0, i1, i2, i3;
  logic signed [COORD_W:0] x1, x2, y1, y2;
  logic [SIZE_W-1:0] w1, h1, w2, h2, iw2, ih2;
  logic [AREA_W-1:0] inter3, barea3;
  logic signed [COORD_W-1:0] dl, dt;
  logic [SIZE_W-1:0] dw, dh;
  logic signed [COORD_W:0] d_lx, d_ty, d_rx, d_by;
  logic signed [COORD_W+1:0] dx, dy;
  logic [PROD_W-1:0] inter_scaled;

  assign is_full  = (count == CNT_W'(MAX_DETECTIONS));
  assign out_free = !out_valid || out_ready;
  assign walk_done = (rd_ptr == count) && !v0 && !v1 && !v2 && !v3;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      overlap_percent <= OVERLAP_DEFAULT;
      area_factor     <= FACTOR_DEFAULT;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_OVERLAP: overlap_percent <= cfg_data;
        REG_FACTOR:  area_factor     <= cfg_data;
        default:     ;
      endcase
    end
  end

  // ---------------- state machine ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (op_t'(op) == OP_TEST) ? S_AREA : S_DONE;
        end
      end
      S_AREA: state_next = S_THR;
      S_THR:  state_next = S_WALK;
      S_WALK: begin
        if (hit || walk_done) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE: in_ready = 1'b1;
      S_WALK: issue    = (rd_ptr != count) && !hit;
      S_DONE: out_load = out_free;
      default: ;
    endcase
  end

  assign ram_we = out_load && (cur_op == OP_ADD) && !is_full;

  // ---------------- transaction latch and slot setup ----------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_op <= op_t'(op);
      sl     <= box_left;
      st     <= box_top;
      sw     <= box_width;
      sh     <= box_height;
    end
    if (state == S_AREA) begin
      slot_area <= AREA_W'(sw) * AREA_W'(sh);
      sl_end    <= {sl[COORD_W-1], sl} + {2'b00, sw};
      st_end    <= {st[COORD_W-1], st} + {2'b00, sh};
    end
    if (state == S_THR) begin
      thr_ov <= PROD_W'(overlap_percent) * PROD_W'(slot_area);
      thr_af <= PROD_W'(area_factor) * PROD_W'(slot_area);
    end
  end

  // ---------------- walk control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      found  <= 1'b0;
    end else begin
      if (state == S_THR) begin
        rd_ptr <= '0;
        found  <= 1'b0;
      end else if (issue) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (hit) begin
        found <= 1'b1;
      end else if (state == S_IDLE) begin
        found <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      match_idx <= i3;
    end
  end

  // ---------------- box store ----------------
  sobo_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_DETECTIONS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata ({sl, st, sw, sh}),
    .raddr (rd_ptr[ADDR_W-1:0]),
    .rdata (rdata)
  );

  // ---------------- overlap pipeline ----------------
  assign {dl, dt, dw, dh} = rdata;
  assign d_lx = {dl[COORD_W-1], dl};
  assign d_ty = {dt[COORD_W-1], dt};
  assign d_rx = d_lx + {2'b00, dw};
  assign d_by = d_ty + {2'b00, dh};

  assign dx = {x2[COORD_W], x2} - {x1[COORD_W], x1};
  assign dy = {y2[COORD_W], y2} - {y1[COORD_W], y1};

  assign inter_scaled = PROD_W'(inter3) * PROD_W'(PCT_SCALE);
  assign hit = v3 && (state == S_WALK) && (inter_scaled >= thr_ov)
               && (PROD_W'(barea3) < thr_af);

  always_ff @(posedge clk) begin
    if (rst || state != S_WALK || hit) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v0 <= issue;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    i0 <= rd_ptr[ADDR_W-1:0];
    i1 <= i0;
    i2 <= i1;
    i3 <= i2;
    // stage 1: edges of the intersection
    x1 <= ($signed({sl[COORD_W-1], sl}) > d_lx) ? $signed({sl[COORD_W-1], sl}) : d_lx;
    y1 <= ($signed({st[COORD_W-1], st}) > d_ty) ? $signed({st[COORD_W-1], st}) : d_ty;
    x2 <= (sl_end < d_rx) ? sl_end : d_rx;
    y2 <= (st_end < d_by) ? st_end : d_by;
    w1 <= dw;
    h1 <= dh;
    // stage 2: intersection extent, empty gives 0
    iw2 <= (!dx[COORD_W+1] && dx != '0) ? dx[SIZE_W-1:0] : '0;
    ih2 <= (!dy[COORD_W+1] && dy != '0) ? dy[SIZE_W-1:0] : '0;
    w2  <= w1;
    h2  <= h1;
    // stage 3: areas
    inter3 <= AREA_W'(iw2) * AREA_W'(ih2);
    barea3 <= AREA_W'(w2) * AREA_W'(h2);
  end

  // ---------------- count and result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (out_load) begin
      case (cur_op)
        OP_CLEAR: count <= '0;
        OP_ADD:   if (!is_full) count <= count + 1'b1;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      occupied    <= (cur_op == OP_TEST) && found;
      match_index <= ((cur_op == OP_TEST) && found) ? IDX_OUT_W'(match_idx) : '0;
      store_full  <= (cur_op == OP_ADD) && is_full;
      case (cur_op)
        OP_CLEAR: detection_count <= '0;
        OP_ADD:   detection_count <= is_full ? CNT_OUT_W'(count)
                                             : CNT_OUT_W'(count + 1'b1);
        default:  detection_count <= CNT_OUT_W'(count);
      endcase
    end
  end

endmodule
